/* hdl/assert_macros.svh */
// Assertion macros for the RTL of the priority queue.
// No dependencies; included by the queue module, which carries the assertions.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Concurrent assertion sampled on the rising clock edge, off while in reset.
`define SAPQ_ASSERT(label, clk, rst, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// Concurrent assertion that is also checked while reset is high.
`define SAPQ_ASSERT_ALWAYS(label, clk, prop, msg) \
  label: assert property (@(posedge clk) (prop)) else $error(msg);

`endif

/* hdl/sapq_pkg.sv */
// Package of the sorted-array priority queue: codes, entry type and FSM states.
// No dependencies; used by the interfaces, the queue module and the verification modules.
`default_nettype none

package sapq_pkg;

  // Operation codes.
  localparam logic OP_ENQ = 1'b0;
  localparam logic OP_DEQ = 1'b1;

  // Result status codes.
  localparam logic [1:0] STAT_OK    = 2'd0;
  localparam logic [1:0] STAT_FULL  = 2'd1;
  localparam logic [1:0] STAT_EMPTY = 2'd2;

  // Field widths.
  localparam int VAL_W  = 16;
  localparam int PRI_W  = 16;
  localparam int OCC_W  = 5;
  localparam int SIZE_W = 5;

  // Reset value of the size register.
  localparam logic [SIZE_W-1:0] QSIZE_RST = 5'd16;

  // One stored entry: priority above payload.
  typedef struct packed {
    logic signed [PRI_W-1:0] pri;
    logic [VAL_W-1:0]        val;
  } entry_t;

  // Sequencer states.
  typedef enum logic [2:0] {
    S_IDLE,
    S_ENQ_RD,
    S_ENQ_CMP,
    S_DEQ_HEAD,
    S_DEQ_RD,
    S_DEQ_WR,
    S_RESP
  } state_t;

endpackage

`default_nettype wire

/* hdl/sapq_if.sv */
// Valid/ready channel interfaces for operations and results of the queue.
// Depends on sapq_pkg for the field widths.
`default_nettype none

interface sapq_cmd_if import sapq_pkg::*; ();
  logic                    valid;
  logic                    ready;
  logic                    opcode;
  logic [VAL_W-1:0]        item_value;
  logic signed [PRI_W-1:0] item_priority;

  modport source (output valid, opcode, item_value, item_priority, input ready);
  modport sink   (input valid, opcode, item_value, item_priority, output ready);
endinterface

interface sapq_res_if import sapq_pkg::*; ();
  logic             valid;
  logic             ready;
  logic [1:0]       status;
  logic [VAL_W-1:0] out_value;
  logic             out_valid;
  logic [OCC_W-1:0] occupancy;

  modport source (output valid, status, out_value, out_valid, occupancy, input ready);
  modport sink   (input valid, status, out_value, out_valid, occupancy, output ready);
endinterface

`default_nettype wire

/* hdl/sapq_ram.sv */
// Generic simple dual-port RAM: one write port, one read port, registered read.
// No dependencies.
`default_nettype none

module sapq_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 16
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port and registered read port.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

/* hdl/sorted_array_priority_queue.sv */
// Sorted-array priority queue: a small sequencer walks an entry RAM kept in
// ascending priority order, front at address zero. An operation is taken only
// while the sequencer is idle; its result waits in an output register. An
// enqueue walks from the back, moving each stored entry of no lower priority
// back one place, and stops at the front or at a strictly lower priority; a
// dequeue takes the front entry and moves each later entry one place forward.
// A refused operation goes straight to its result. Each step of an enqueue
// walk is one read of the entry RAM, one priority compare and one write; a
// dequeue step is one read and one write. The RAM contents are undefined after
// reset; only entries below the count are ever used. Depends on sapq_pkg,
// sapq_if, sapq_ram and assert_macros.svh.
`default_nettype none

`include "assert_macros.svh"

module sorted_array_priority_queue import sapq_pkg::*; #(
  parameter int CAPACITY = 16
) (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              cfg_we,
  input  wire logic [SIZE_W-1:0] cfg_wdata,
  sapq_cmd_if.sink               cmd,
  sapq_res_if.source             res
);

  localparam int AW = $clog2(CAPACITY);
  localparam int CW = $clog2(CAPACITY + 1);

  state_t state, state_next;

  // Configuration and occupancy.
  logic [SIZE_W-1:0] qsize;
  logic [CW-1:0]     count, count_next;
  logic [CW-1:0]     idx, idx_next;

  // Operation held while the sequencer works on it.
  logic                    cur_op;
  logic [VAL_W-1:0]        cur_val;
  logic signed [PRI_W-1:0] cur_pri;

  // Result built by the sequencer, then the output register.
  logic [1:0]       pend_status, pend_status_next;
  logic [VAL_W-1:0] pend_value, pend_value_next;
  logic             pend_flag, pend_flag_next;
  logic             res_valid, res_load;
  logic [1:0]       res_status;
  logic [VAL_W-1:0] res_value;
  logic             res_flag;
  logic [OCC_W-1:0] res_occ;

  // Entry RAM ports.
  logic          ram_we;
  logic [AW-1:0] ram_waddr, ram_raddr;
  entry_t        ram_wdata, ram_rdata;

  logic          accept, full;
  logic [CW-1:0] idx_m1;
  entry_t        new_entry;

  assign accept    = cmd.valid && cmd.ready;
  assign full      = (32'(count) >= 32'(qsize)) || (32'(count) >= 32'(CAPACITY));
  assign idx_m1    = idx - 1'b1;
  assign new_entry = '{pri: cur_pri, val: cur_val};

  sapq_ram #(
    .WIDTH ($bits(entry_t)),
    .DEPTH (CAPACITY)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  // State register.
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Next state, walk control and RAM accesses.
  always_comb begin
    state_next       = state;
    count_next       = count;
    idx_next         = idx;
    pend_status_next = pend_status;
    pend_value_next  = pend_value;
    pend_flag_next   = pend_flag;
    ram_we           = 1'b0;
    ram_waddr        = '0;
    ram_wdata        = ram_rdata;
    ram_raddr        = '0;
    res_load         = 1'b0;
    cmd.ready        = 1'b0;
    unique case (state)
      S_IDLE: begin
        cmd.ready        = 1'b1;
        pend_status_next = STAT_OK;
        pend_value_next  = '0;
        pend_flag_next   = 1'b0;
        if (accept) begin
          if (cmd.opcode == OP_ENQ) begin
            if (full) begin
              pend_status_next = STAT_FULL;
              state_next       = S_RESP;
            end else begin
              idx_next   = count;
              state_next = S_ENQ_RD;
            end
          end else begin
            if (count == '0) begin
              pend_status_next = STAT_EMPTY;
              state_next       = S_RESP;
            end else begin
              // The read of the front entry is issued here.
              state_next = S_DEQ_HEAD;
            end
          end
        end
      end
      S_ENQ_RD: begin
        if (idx == '0) begin
          // Every stored entry moved back: the new one goes to the front.
          ram_we     = 1'b1;
          ram_waddr  = '0;
          ram_wdata  = new_entry;
          count_next = count + 1'b1;
          state_next = S_RESP;
        end else begin
          ram_raddr  = idx_m1[AW-1:0];
          state_next = S_ENQ_CMP;
        end
      end
      S_ENQ_CMP: begin
        ram_we    = 1'b1;
        ram_waddr = idx[AW-1:0];
        if (ram_rdata.pri < cur_pri) begin
          // Strictly lower priority ahead: the new entry lands just behind it.
          ram_wdata  = new_entry;
          count_next = count + 1'b1;
          state_next = S_RESP;
        end else begin
          ram_wdata  = ram_rdata;
          idx_next   = idx_m1;
          state_next = S_ENQ_RD;
        end
      end
      S_DEQ_HEAD: begin
        pend_value_next = ram_rdata.val;
        pend_flag_next  = 1'b1;
        idx_next        = CW'(1);
        state_next      = S_DEQ_RD;
      end
      S_DEQ_RD: begin
        if (idx >= count) begin
          count_next = count - 1'b1;
          state_next = S_RESP;
        end else begin
          ram_raddr  = idx[AW-1:0];
          state_next = S_DEQ_WR;
        end
      end
      S_DEQ_WR: begin
        // Move the entry just read one place toward the front.
        ram_we     = 1'b1;
        ram_waddr  = idx_m1[AW-1:0];
        ram_wdata  = ram_rdata;
        idx_next   = idx + 1'b1;
        state_next = S_DEQ_RD;
      end
      S_RESP: begin
        if (!res_valid || res.ready) begin
          res_load   = 1'b1;
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  // Control registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      qsize     <= QSIZE_RST;
      count     <= '0;
      idx       <= '0;
      res_valid <= 1'b0;
    end else begin
      if (cfg_we) begin
        qsize <= cfg_wdata;
      end
      count <= count_next;
      idx   <= idx_next;
      if (res_load) begin
        res_valid <= 1'b1;
      end else if (res.ready) begin
        res_valid <= 1'b0;
      end
    end
  end

  // Payload registers.
  always_ff @(posedge clk) begin
    if (accept) begin
      cur_op  <= cmd.opcode;
      cur_val <= cmd.item_value;
      cur_pri <= cmd.item_priority;
    end
    pend_status <= pend_status_next;
    pend_value  <= pend_value_next;
    pend_flag   <= pend_flag_next;
    if (res_load) begin
      res_status <= pend_status;
      res_value  <= pend_value;
      res_flag   <= pend_flag && (cur_op == OP_DEQ);
      res_occ    <= OCC_W'(count);
    end
  end

  // Result channel.
  assign res.valid     = res_valid;
  assign res.status    = res_status;
  assign res.out_value = res_value;
  assign res.out_valid = res_flag;
  assign res.occupancy = res_occ;

  // Checks on the sequencer and the result it hands over.
  `SAPQ_ASSERT(a_idle_count_stable, clk, rst, (state == S_IDLE) |=> $stable(count), "count changed while idle")
  `SAPQ_ASSERT(a_count_bound, clk, rst, count <= CW'(CAPACITY), "count above capacity")
  `SAPQ_ASSERT(a_enq_idx_bound, clk, rst, (state == S_ENQ_RD) |-> (idx <= count), "enqueue walk index past count")
  `SAPQ_ASSERT(a_payload_ok, clk, rst, (res.valid && res.out_valid) |-> (res.status == STAT_OK), "dequeued payload without success status")

endmodule

`default_nettype wire

/* verif/sapq_scoreboard.sv */
// Scoreboard for the sorted-array priority queue: tracks the queue contents,
// predicts every result and checks the result channel field by field.
// Depends on sapq_pkg and the channel interfaces in sapq_if.
module sapq_scoreboard import sapq_pkg::*; #(
  parameter int CAPACITY = 16
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              cfg_we,
  input  logic [SIZE_W-1:0] cfg_wdata,
  sapq_cmd_if               cmd,
  sapq_res_if               res,
  output int                fail_count,
  output int                in_flight
);
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    logic [1:0]       status;
    logic [VAL_W-1:0] value;
    logic             taken;
    logic [OCC_W-1:0] occupancy;
  } queue_result_t;

  // Shadow copy of the sorted store, front at index zero.
  logic [VAL_W-1:0]        shadow_val [CAPACITY];
  logic signed [PRI_W-1:0] shadow_pri [CAPACITY];
  int                      shadow_count;
  logic [SIZE_W-1:0]       size_reg;
  queue_result_t           awaited_results[$];

  // Applies one operation to the shadow store and returns its result.
  function automatic queue_result_t apply_queue_op(logic op, logic [VAL_W-1:0] v,
                                                   logic signed [PRI_W-1:0] p);
    queue_result_t r;
    int            limit;
    int            slot;
    r = '0;
    limit = (int'(size_reg) < CAPACITY) ? int'(size_reg) : CAPACITY;
    if (op == OP_ENQ) begin
      if (shadow_count >= limit) begin
        r.status = STAT_FULL;
      end else begin
        // The newcomer goes just past the last entry with a strictly lower priority.
        slot = 0;
        for (int i = shadow_count; i > 0; i--) begin
          if (shadow_pri[i-1] < p) begin
            slot = i;
            break;
          end
        end
        for (int i = shadow_count; i > slot; i--) begin
          shadow_val[i] = shadow_val[i-1];
          shadow_pri[i] = shadow_pri[i-1];
        end
        shadow_val[slot] = v;
        shadow_pri[slot] = p;
        shadow_count++;
        r.status = STAT_OK;
      end
    end else begin
      if (shadow_count == 0) begin
        r.status = STAT_EMPTY;
      end else begin
        r.status = STAT_OK;
        r.value = shadow_val[0];
        r.taken = 1'b1;
        for (int i = 1; i < shadow_count; i++) begin
          shadow_val[i-1] = shadow_val[i];
          shadow_pri[i-1] = shadow_pri[i];
        end
        shadow_count--;
      end
    end
    r.occupancy = OCC_W'(shadow_count);
    return r;
  endfunction

  // Track configuration, predict on each operation transfer, check each result transfer.
  always @(posedge clk) begin
    queue_result_t want;
    if (rst) begin
      shadow_count = 0;
      size_reg = QSIZE_RST;
      awaited_results.delete();
      fail_count = 0;
    end else begin
      if (cfg_we) begin
        size_reg = cfg_wdata;
      end
      if (res.valid && res.ready) begin
        if (awaited_results.size() == 0) begin
          $error("result transfer with no operation outstanding");
          fail_count++;
        end else begin
          want = awaited_results.pop_front();
          if (res.status !== want.status) begin
            $error("status: expected %0d, got %0d", want.status, res.status);
            fail_count++;
          end
          if (res.out_value !== want.value) begin
            $error("out_value: expected %0h, got %0h", want.value, res.out_value);
            fail_count++;
          end
          if (res.out_valid !== want.taken) begin
            $error("out_valid: expected %0b, got %0b", want.taken, res.out_valid);
            fail_count++;
          end
          if (res.occupancy !== want.occupancy) begin
            $error("occupancy: expected %0d, got %0d", want.occupancy, res.occupancy);
            fail_count++;
          end
        end
      end
      if (cmd.valid && cmd.ready) begin
        awaited_results.push_back(apply_queue_op(cmd.opcode, cmd.item_value,
                                                 cmd.item_priority));
      end
    end
    in_flight = awaited_results.size();
  end

  initial begin
    fail_count = 0;
    in_flight = 0;
    shadow_count = 0;
    size_reg = QSIZE_RST;
  end
endmodule

/* verif/tb_sorted_array_priority_queue.sv */
// Testbench top for the sorted-array priority queue: clock, reset, operation
// stimulus, result back-pressure and the verdict. Depends on sapq_pkg, sapq_if,
// the queue RTL and the sapq_scoreboard checker.
module tb_sorted_array_priority_queue;
  import sapq_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int DEPTH = 16;
  localparam int CFG_SETTLE = 4;
  localparam int END_SETTLE = 80;

  logic              clk;
  logic              rst;
  logic              cfg_we;
  logic [SIZE_W-1:0] cfg_wdata;
  int                fail_count;
  int                in_flight;
  int                send_idle;
  int                recv_idle;

  sapq_cmd_if cmd_ch ();
  sapq_res_if res_ch ();

  sorted_array_priority_queue #(.CAPACITY(DEPTH)) dut (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .cmd       (cmd_ch),
    .res       (res_ch)
  );

  sapq_scoreboard #(.CAPACITY(DEPTH)) checker_i (
    .clk        (clk),
    .rst        (rst),
    .cfg_we     (cfg_we),
    .cfg_wdata  (cfg_wdata),
    .cmd        (cmd_ch),
    .res        (res_ch),
    .fail_count (fail_count),
    .in_flight  (in_flight)
  );

  // Free-running clock with a 4 ns period.
  initial clk = 1'b0;
  always #2 clk = ~clk;

  // Result back-pressure, redrawn every cycle.
  initial begin
    res_ch.ready = 1'b0;
    forever begin
      @(negedge clk);
      res_ch.ready = ($urandom_range(99) >= recv_idle);
    end
  end

  // Hard stop in case the queue hangs.
  initial begin
    #2000000;
    $display("== FAIL ==");
    $finish;
  end

  // Presents one operation, possibly after some idle cycles, and waits for its transfer.
  task automatic send_op(input logic op, input logic [VAL_W-1:0] v,
                         input logic signed [PRI_W-1:0] p);
    while ($urandom_range(99) < send_idle) begin
      cmd_ch.valid = 1'b0;
      @(negedge clk);
    end
    cmd_ch.valid = 1'b1;
    cmd_ch.opcode = op;
    cmd_ch.item_value = v;
    cmd_ch.item_priority = p;
    @(posedge clk);
    while (!cmd_ch.ready) @(posedge clk);
    @(negedge clk);
  endtask

  // Holds off the sender until every outstanding result has been transferred.
  task automatic wait_drained();
    cmd_ch.valid = 1'b0;
    while (in_flight != 0) @(negedge clk);
  endtask

  // Writes the size register once the queue is idle.
  task automatic set_queue_size(input logic [SIZE_W-1:0] size);
    wait_drained();
    repeat (CFG_SETTLE) @(negedge clk);
    cfg_we = 1'b1;
    cfg_wdata = size;
    @(negedge clk);
    cfg_we = 1'b0;
  endtask

  // Mostly small priorities so that ties are common, sometimes the full range.
  function automatic logic signed [PRI_W-1:0] pick_priority();
    if ($urandom_range(2) == 0) return PRI_W'($urandom);
    return PRI_W'(int'($urandom_range(8)) - 4);
  endfunction

  // Main stimulus: reset, directed cases, then random phases at several sizes.
  initial begin
    logic [SIZE_W-1:0] phase_size [9];
    int                run_left;
    bit                filling;
    logic              op;

    rst = 1'b1;
    cfg_we = 1'b0;
    cfg_wdata = '0;
    cmd_ch.valid = 1'b0;
    cmd_ch.opcode = OP_ENQ;
    cmd_ch.item_value = '0;
    cmd_ch.item_priority = '0;
    send_idle = 20;
    recv_idle = 70;
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // Empty dequeue first; its payload fields are ignored.
    send_op(OP_DEQ, 16'hFFFF, 16'sh8000);
    // Priority extremes, a tie (the newer one leaves first), and neighbors of zero.
    send_op(OP_ENQ, 16'h0000, 16'sh8000);
    send_op(OP_ENQ, 16'hFFFF, 16'sh7FFF);
    send_op(OP_ENQ, 16'h0001, 16'sh0000);
    send_op(OP_ENQ, 16'h0002, 16'sh0000);
    send_op(OP_ENQ, 16'h0003, -16'sd1);
    send_op(OP_ENQ, 16'h0004, 16'sd1);
    repeat (7) send_op(OP_DEQ, '0, '0);

    // A size of zero refuses every enqueue.
    set_queue_size(5'd0);
    send_op(OP_ENQ, 16'h5A5A, 16'sd3);
    send_op(OP_DEQ, '0, '0);

    // Fill a small queue past its limit, then lower the limit below the count.
    set_queue_size(5'd2);
    send_op(OP_ENQ, 16'h1111, 16'sd5);
    send_op(OP_ENQ, 16'h2222, -16'sd5);
    send_op(OP_ENQ, 16'h3333, 16'sd0);
    set_queue_size(5'd1);
    send_op(OP_ENQ, 16'h4444, -16'sd9);
    send_op(OP_DEQ, '0, '0);
    send_op(OP_ENQ, 16'h5555, -16'sd9);
    send_op(OP_DEQ, '0, '0);
    send_op(OP_DEQ, '0, '0);

    // Random phases; sizes beyond the capacity clamp to it.
    phase_size[0] = 5'd31;
    phase_size[1] = 5'd16;
    phase_size[2] = 5'd1;
    phase_size[3] = SIZE_W'($urandom_range(15, 2));
    phase_size[4] = 5'd0;
    phase_size[5] = SIZE_W'($urandom_range(30, 17));
    phase_size[6] = 5'd16;
    phase_size[7] = 5'd3;
    phase_size[8] = SIZE_W'($urandom_range(31));
    for (int ph = 0; ph < 9; ph++) begin
      set_queue_size(phase_size[ph]);
      if (ph < 3) begin
        send_idle = 20;
        recv_idle = 70;
      end else if (ph < 6) begin
        send_idle = 70;
        recv_idle = 20;
      end else begin
        send_idle = 0;
        recv_idle = 0;
      end
      filling = 1'b1;
      run_left = $urandom_range(30, 10);
      for (int n = 0; n < 55; n++) begin
        // Alternate fill and drain runs so the queue swings between empty and full.
        if (run_left == 0) begin
          filling = !filling;
          run_left = $urandom_range(30, 10);
        end
        run_left--;
        if (filling) op = ($urandom_range(99) < 80) ? OP_ENQ : OP_DEQ;
        else op = ($urandom_range(99) < 20) ? OP_ENQ : OP_DEQ;
        send_op(op, VAL_W'($urandom), pick_priority());
        if ($urandom_range(39) == 0) wait_drained();
      end
    end

    wait_drained();
    repeat (END_SETTLE) @(negedge clk);
    if (fail_count == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end
endmodule
